// ===== src/srrw_pkg.sv =====
`timescale 1ns / 1ps
package srrw_pkg;

  localparam int WINDOW_DEF = 16;
  localparam int IDX_W      = 23;
  localparam int OFF_W      = 33;
  localparam int CNT_W      = 10;
  localparam int TOUT_W     = 16;
  localparam int TIME_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CNT_W-1:0]  SEG_BYTES   = 10'd1000;
  localparam logic [TOUT_W-1:0] TIMEOUT_RST = 16'd1000;

  localparam logic IN_TICK    = 1'b0;
  localparam logic IN_ARRIVAL = 1'b1;

  localparam logic [1:0] OUT_REQUEST  = 2'd0;
  localparam logic [1:0] OUT_DELIVER  = 2'd1;
  localparam logic [1:0] OUT_COMPLETE = 2'd2;

  localparam logic REG_TOTAL   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic load;
    logic mark_step;
    logic deliver;
    logic done_chk;
    logic request;
    logic scan_init;
    logic tout_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mark_active;
    logic mark_hit;
    logic can_deliver;
    logic can_request;
    logic is_tick;
    logic tout_active;
  } stat_t;

endpackage

// ===== src/srrw_regs.sv =====
`timescale 1ns / 1ps
module srrw_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srrw_pkg::ADDR_W-1:0]       paddr,
  input  logic [srrw_pkg::DATA_W-1:0]       pwdata,
  output logic [srrw_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output logic [31:0]                       total_bytes,
  output logic [srrw_pkg::TOUT_W-1:0]       retry_ticks
);

  logic [31:0]                 total_r;
  logic [srrw_pkg::TOUT_W-1:0] timeout_r;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      timeout_r <= srrw_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        srrw_pkg::REG_TOTAL:   total_r   <= pwdata;
        srrw_pkg::REG_TIMEOUT: timeout_r <= pwdata[srrw_pkg::TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      srrw_pkg::REG_TOTAL:   prdata = total_r;
      srrw_pkg::REG_TIMEOUT: prdata = {{(srrw_pkg::DATA_W-srrw_pkg::TOUT_W){1'b0}}, timeout_r};
      default:               prdata = '0;
    endcase
  end

  assign total_bytes = total_r;
  assign retry_ticks = timeout_r;

endmodule

// ===== src/srrw_ctrl.sv =====
`timescale 1ns / 1ps
module srrw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  srrw_pkg::stat_t stat,
  output srrw_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MARK  = 3'd1;
  localparam logic [2:0] S_DELIV = 3'd2;
  localparam logic [2:0] S_REQ   = 3'd3;
  localparam logic [2:0] S_TOUT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (stat.mark_active) begin
          cmd.mark_step = 1'b1;
          if (stat.mark_hit) begin
            state_nxt = S_DELIV;
          end
        end else begin
          state_nxt = S_DELIV;
        end
      end
      S_DELIV: begin
        if (stat.can_deliver) begin
          cmd.deliver = 1'b1;
        end else begin
          cmd.done_chk = 1'b1;
          state_nxt    = S_REQ;
        end
      end
      S_REQ: begin
        if (stat.can_request) begin
          cmd.request = 1'b1;
        end else if (stat.is_tick) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_TOUT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TOUT: begin
        if (stat.tout_active) begin
          cmd.tout_step = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== src/srrw_dpath.sv =====
`timescale 1ns / 1ps
module srrw_dpath #(
  parameter int WINDOW = srrw_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srrw_pkg::cmd_t                    cmd,
  output srrw_pkg::stat_t                   stat,
  input  logic                              in_kind,
  input  logic [31:0]                       in_seg_offset,
  input  logic [31:0]                       total_bytes,
  input  logic [srrw_pkg::TOUT_W-1:0]       retry_ticks,
  output logic                              out_valid,
  output logic [1:0]                        out_kind,
  output logic [srrw_pkg::IDX_W-1:0]        out_seg_index,
  output logic [31:0]                       out_byte_offset,
  output logic [srrw_pkg::CNT_W-1:0]        out_byte_count,
  output logic                              out_last
);

  localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int IDX_W = srrw_pkg::IDX_W;
  localparam int OFF_W = srrw_pkg::OFF_W;
  localparam int TW    = srrw_pkg::TIME_W;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == SW'(WINDOW - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  logic                    kind_r;
  logic [31:0]             off_r;
  logic [TW-1:0]           now_r;
  logic [IDX_W-1:0]        base_r;
  logic [OFF_W-1:0]        base_off_r;
  logic [SW-1:0]           base_slot_r;
  logic [IDX_W-1:0]        nu_r;
  logic [OFF_W-1:0]        nu_off_r;
  logic [SW-1:0]           nu_slot_r;
  logic [IDX_W-1:0]        scan_r;
  logic [OFF_W-1:0]        scan_off_r;
  logic [SW-1:0]           scan_slot_r;
  logic [WINDOW-1:0]       recv_r;
  logic [TW-1:0]           sent_r [WINDOW];
  logic                    done_r;

  logic                    pend_v_r;
  logic [1:0]              pend_kind_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic [OFF_W-1:0]        pend_off_r;

  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [31:0]             out_off_r;
  logic [srrw_pkg::CNT_W-1:0] out_cnt_r;
  logic                    out_last_r;

  logic [OFF_W-1:0]        total_x;
  logic [OFF_W-1:0]        off_x;
  logic [OFF_W-1:0]        seg_bytes_x;
  logic [OFF_W-1:0]        scan_end;
  logic [IDX_W-1:0]        nu_gap;
  logic [TW-1:0]           age;
  logic                    expired;
  logic                    need_done;

  logic                    cand_v;
  logic [1:0]              cand_kind;
  logic [IDX_W-1:0]        cand_idx;
  logic [OFF_W-1:0]        cand_off;
  logic                    emit_out;

  logic [OFF_W:0]          pend_end;
  logic [OFF_W-1:0]        pend_rem;
  logic [srrw_pkg::CNT_W-1:0] pend_cnt;

  assign total_x     = OFF_W'(total_bytes);
  assign off_x       = OFF_W'(off_r);
  assign seg_bytes_x = OFF_W'(srrw_pkg::SEG_BYTES);
  assign scan_end    = scan_off_r + seg_bytes_x;
  assign nu_gap      = nu_r - base_r;
  assign age         = now_r - sent_r[scan_slot_r];
  assign expired     = !recv_r[scan_slot_r] && (age > TW'(retry_ticks));
  assign need_done   = (base_off_r >= total_x) && !done_r;

  always_comb begin
    stat.mark_active = (kind_r == srrw_pkg::IN_ARRIVAL) && (scan_r != nu_r);
    stat.mark_hit    = (off_x >= scan_off_r) && (off_x < scan_end) && (scan_off_r < total_x);
    stat.can_deliver = (base_off_r < total_x) && (base_r != nu_r) && recv_r[base_slot_r];
    stat.can_request = (nu_gap < IDX_W'(WINDOW)) && (nu_off_r < total_x);
    stat.is_tick     = (kind_r == srrw_pkg::IN_TICK);
    stat.tout_active = (scan_r != nu_r) && (scan_off_r < total_x);
  end

  always_comb begin
    cand_v    = 1'b0;
    cand_kind = srrw_pkg::OUT_REQUEST;
    cand_idx  = '0;
    cand_off  = '0;
    if (cmd.deliver) begin
      cand_v    = 1'b1;
      cand_kind = srrw_pkg::OUT_DELIVER;
      cand_idx  = base_r;
      cand_off  = base_off_r;
    end else if (cmd.done_chk && need_done) begin
      cand_v    = 1'b1;
      cand_kind = srrw_pkg::OUT_COMPLETE;
    end else if (cmd.request) begin
      cand_v    = 1'b1;
      cand_kind = srrw_pkg::OUT_REQUEST;
      cand_idx  = nu_r;
      cand_off  = nu_off_r;
    end else if (cmd.tout_step && expired) begin
      cand_v    = 1'b1;
      cand_kind = srrw_pkg::OUT_REQUEST;
      cand_idx  = scan_r;
      cand_off  = scan_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= srrw_pkg::IN_TICK;
      off_r       <= '0;
      now_r       <= '0;
      base_r      <= '0;
      base_off_r  <= '0;
      base_slot_r <= '0;
      nu_r        <= '0;
      nu_off_r    <= '0;
      nu_slot_r   <= '0;
      scan_r      <= '0;
      scan_off_r  <= '0;
      scan_slot_r <= '0;
      recv_r      <= '0;
      done_r      <= 1'b0;
    end else begin
      if (cmd.load) begin
        kind_r      <= in_kind;
        off_r       <= in_seg_offset;
        scan_r      <= base_r;
        scan_off_r  <= base_off_r;
        scan_slot_r <= base_slot_r;
        if (in_kind == srrw_pkg::IN_TICK) begin
          now_r <= now_r + 1'b1;
        end
      end
      if (cmd.mark_step) begin
        if (stat.mark_hit) begin
          recv_r[scan_slot_r] <= 1'b1;
        end else begin
          scan_r      <= scan_r + 1'b1;
          scan_off_r  <= scan_end;
          scan_slot_r <= slot_inc(scan_slot_r);
        end
      end
      if (cmd.deliver) begin
        recv_r[base_slot_r] <= 1'b0;
        base_r      <= base_r + 1'b1;
        base_off_r  <= base_off_r + seg_bytes_x;
        base_slot_r <= slot_inc(base_slot_r);
      end
      if (cmd.done_chk && need_done) begin
        done_r <= 1'b1;
      end
      if (cmd.request) begin
        recv_r[nu_slot_r] <= 1'b0;
        nu_r      <= nu_r + 1'b1;
        nu_off_r  <= nu_off_r + seg_bytes_x;
        nu_slot_r <= slot_inc(nu_slot_r);
      end
      if (cmd.scan_init) begin
        scan_r      <= base_r;
        scan_off_r  <= base_off_r;
        scan_slot_r <= base_slot_r;
      end
      if (cmd.tout_step) begin
        scan_r      <= scan_r + 1'b1;
        scan_off_r  <= scan_end;
        scan_slot_r <= slot_inc(scan_slot_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.request) begin
      sent_r[nu_slot_r] <= now_r;
    end else if (cmd.tout_step && expired) begin
      sent_r[scan_slot_r] <= now_r;
    end
  end

  // A result leaves only once the next one, or the end of the item, is known,
  // so that the final transfer of each item carries the last flag.
  assign emit_out = pend_v_r && (cand_v || cmd.finish);

  assign pend_end = {1'b0, pend_off_r} + {1'b0, seg_bytes_x};
  assign pend_rem = total_x - pend_off_r;

  always_comb begin
    if (pend_kind_r == srrw_pkg::OUT_COMPLETE) begin
      pend_cnt = '0;
    end else if (pend_end <= {1'b0, total_x}) begin
      pend_cnt = srrw_pkg::SEG_BYTES;
    end else if (total_x > pend_off_r) begin
      pend_cnt = pend_rem[srrw_pkg::CNT_W-1:0];
    end else begin
      pend_cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cand_v) begin
        pend_v_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_v_r <= 1'b0;
      end
      out_valid_r <= emit_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_v) begin
      pend_kind_r <= cand_kind;
      pend_idx_r  <= cand_idx;
      pend_off_r  <= cand_off;
    end
    if (emit_out) begin
      out_kind_r <= pend_kind_r;
      out_idx_r  <= pend_idx_r;
      out_off_r  <= pend_off_r[31:0];
      out_cnt_r  <= pend_cnt;
      out_last_r <= cmd.finish;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_seg_index   = out_idx_r;
  assign out_byte_offset = out_off_r;
  assign out_byte_count  = out_cnt_r;
  assign out_last        = out_last_r;

endmodule

// ===== src/selective_repeat_request_window_core.sv =====
`timescale 1ns / 1ps
// After the accepting edge busy stays high through these steps in order: mark steps (none on
// a tick; on an arrival the scan walks the window to the hit or to the next unsent segment),
// deliveries of in-order segments, a done check, new requests while the window has room, a
// timeout scan on a tick, and a final flush. The next item is taken in the first idle cycle.
// Each result is strobed the cycle after the next result's step, the last in that first idle
// cycle; the receiver cannot stall. Synchronous active-low reset clears control state only.
module selective_repeat_request_window_core #(
  parameter int WINDOW = srrw_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic [31:0]                       in_seg_offset,
  output logic                              out_valid,
  output logic [1:0]                        out_kind,
  output logic [srrw_pkg::IDX_W-1:0]        out_seg_index,
  output logic [31:0]                       out_byte_offset,
  output logic [srrw_pkg::CNT_W-1:0]        out_byte_count,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srrw_pkg::ADDR_W-1:0]       paddr,
  input  logic [srrw_pkg::DATA_W-1:0]       pwdata,
  output logic [srrw_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  srrw_pkg::cmd_t              cmd;
  srrw_pkg::stat_t             stat;
  logic [31:0]                 total_bytes;
  logic [srrw_pkg::TOUT_W-1:0] retry_ticks;

  srrw_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .total_bytes (total_bytes),
    .retry_ticks (retry_ticks)
  );

  srrw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  srrw_dpath #(
    .WINDOW (WINDOW)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_seg_offset   (in_seg_offset),
    .total_bytes     (total_bytes),
    .retry_ticks     (retry_ticks),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_seg_index   (out_seg_index),
    .out_byte_offset (out_byte_offset),
    .out_byte_count  (out_byte_count),
    .out_last        (out_last)
  );

endmodule
